[hdl/cau_pkg.sv]
// ---------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes, status codes and the depth and address width of the command queue.
// ---------------------------------------------------------------------------
package cau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIV0 = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;

endpackage

[hdl/cau_front.sv]
// ---------------------------------------------------------------------------
// Complex arithmetic unit front end
// Registers commands, classifies them and pushes them into a short queue.
// ---------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            cmd,
	input  logic [DATA_WIDTH-1:0] a_re,
	input  logic [DATA_WIDTH-1:0] a_im,
	input  logic [DATA_WIDTH-1:0] b_re,
	input  logic [DATA_WIDTH-1:0] b_im,
	input  logic                  pop,
	output logic                  busy,
	output logic                  q_valid,
	output op_t                   q_op,
	output logic                  q_zero,
	output logic [DATA_WIDTH-1:0] q_a_re,
	output logic [DATA_WIDTH-1:0] q_a_im,
	output logic [DATA_WIDTH-1:0] q_b_re,
	output logic [DATA_WIDTH-1:0] q_b_im
);

	localparam int W = 4 * DATA_WIDTH + 3;

	logic [W-1:0]        mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                push;
	logic [W-1:0]        rec;

	assign push = start && !busy;
	assign busy = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign rec = {cmd, (b_re == '0) && (b_im == '0), a_re, a_im, b_re, b_im};

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
		end
	end

	assign q_valid = (cnt_q != '0);
	assign q_op    = op_t'(mem_q[rd_q][W-1:W-2]);
	assign q_zero  = mem_q[rd_q][W-3];
	assign q_a_re  = mem_q[rd_q][4*DATA_WIDTH-1:3*DATA_WIDTH];
	assign q_a_im  = mem_q[rd_q][3*DATA_WIDTH-1:2*DATA_WIDTH];
	assign q_b_re  = mem_q[rd_q][2*DATA_WIDTH-1:DATA_WIDTH];
	assign q_b_im  = mem_q[rd_q][DATA_WIDTH-1:0];

endmodule

[hdl/cau_back.sv]
// ---------------------------------------------------------------------------
// Complex arithmetic unit back end
// Pipelined products followed by a bit-serial restoring divider.
// ---------------------------------------------------------------------------
module cau_back import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  op_t                   q_op,
	input  logic                  q_zero,
	input  logic [DATA_WIDTH-1:0] q_a_re,
	input  logic [DATA_WIDTH-1:0] q_a_im,
	input  logic [DATA_WIDTH-1:0] q_b_re,
	input  logic [DATA_WIDTH-1:0] q_b_im,
	output logic                  pop,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] res_re,
	output logic [DATA_WIDTH-1:0] res_im,
	output logic [1:0]            status
);

	localparam int DW  = DATA_WIDTH;
	localparam int PW  = 2 * DW + 2;
	localparam int NW  = PW + FRAC_BITS;
	localparam int CW  = $clog2(NW + 1);

	typedef enum logic [2:0] {
		S_RUN  = 3'b001,
		S_DIV  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic          v_s1;
	op_t           op_s1;
	logic          z_s1;
	logic signed [2*DW-1:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [DW:0]     ar_s1, ai_s1;
	logic signed [PW-1:0]   re_c, im_c;
	logic          div_go;
	logic [NW-1:0] nre_q, nim_q;
	logic [PW:0]   rre_q, rim_q;
	logic [PW-1:0] den_q;
	logic          sre_q, sim_q;
	logic [CW-1:0] cnt_q;
	logic [PW:0]   tre, tim;

	function automatic logic [DW:0] sat(input logic signed [NW:0] v);
		logic signed [NW:0] mx, mn;
		mx = (NW+1)'({1'b0, {(DW-1){1'b1}}});
		mn = -mx - (NW+1)'(1);
		if (v > mx) return {1'b1, 1'b0, {(DW-1){1'b1}}};
		if (v < mn) return {1'b1, 1'b1, {(DW-1){1'b0}}};
		return {1'b0, v[DW-1:0]};
	endfunction

	logic [DW:0] sre, sim;
	logic signed [NW:0] vre, vim;

	assign div_go = v_s1 && (op_s1 == OP_DIV) && !z_s1;
	assign pop = q_valid && (state_q == S_RUN) && !div_go;

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1 <= q_op;
			z_s1  <= q_zero;
			p0_s1 <= $signed(q_a_re) * $signed(q_b_re);
			p1_s1 <= $signed(q_a_im) * $signed(q_b_im);
			p2_s1 <= $signed(q_a_re) * $signed(q_b_im);
			p3_s1 <= $signed(q_a_im) * $signed(q_b_re);
			ar_s1 <= (q_op == OP_SUB) ? $signed({q_a_re[DW-1], q_a_re}) - $signed({q_b_re[DW-1], q_b_re})
			                         : $signed({q_a_re[DW-1], q_a_re}) + $signed({q_b_re[DW-1], q_b_re});
			ai_s1 <= (q_op == OP_SUB) ? $signed({q_a_im[DW-1], q_a_im}) - $signed({q_b_im[DW-1], q_b_im})
			                         : $signed({q_a_im[DW-1], q_a_im}) + $signed({q_b_im[DW-1], q_b_im});
		end
	end

	always_comb begin
		re_c = '0;
		im_c = '0;
		unique case (op_s1)
			OP_MUL: begin
				re_c = PW'(p0_s1) - PW'(p1_s1);
				im_c = PW'(p2_s1) + PW'(p3_s1);
			end
			OP_DIV: begin
				re_c = PW'(p0_s1) + PW'(p1_s1);
				im_c = PW'(p3_s1) - PW'(p2_s1);
			end
			default: begin
				re_c = PW'(ar_s1);
				im_c = PW'(ai_s1);
			end
		endcase
		vre = (op_s1 == OP_MUL) ? (NW+1)'(re_c >>> FRAC_BITS) : (NW+1)'(re_c);
		vim = (op_s1 == OP_MUL) ? (NW+1)'(im_c >>> FRAC_BITS) : (NW+1)'(im_c);
		if (state_q == S_DONE) begin
			vre = sre_q ? -$signed({1'b0, nre_q}) : $signed({1'b0, nre_q});
			vim = sim_q ? -$signed({1'b0, nim_q}) : $signed({1'b0, nim_q});
		end
		sre = sat(vre);
		sim = sat(vim);
	end

	logic [PW-1:0] dsq_s1;
	logic signed [2*DW-1:0] bre2, bim2;
	assign bre2 = $signed(q_b_re) * $signed(q_b_re);
	assign bim2 = $signed(q_b_im) * $signed(q_b_im);
	always_ff @(posedge clk) begin
		if (pop) dsq_s1 <= PW'(bre2) + PW'(bim2);
	end

	assign tre = {rre_q[PW-1:0], nre_q[NW-1]} - {1'b0, den_q};
	assign tim = {rim_q[PW-1:0], nim_q[NW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			v_s1    <= 1'b0;
			done    <= 1'b0;
			cnt_q   <= '0;
			res_re  <= '0;
			res_im  <= '0;
			status  <= ST_OK;
			den_q   <= '0;
			sre_q   <= 1'b0;
			sim_q   <= 1'b0;
			nre_q   <= '0;
			nim_q   <= '0;
			rre_q   <= '0;
			rim_q   <= '0;
		end else begin
			unique case (state_q)
				S_RUN: begin
					v_s1 <= pop;
					done <= v_s1 && !div_go;
					if (v_s1 && !div_go) begin
						res_re <= z_s1 && op_s1 == OP_DIV ? '0 : sre[DW-1:0];
						res_im <= z_s1 && op_s1 == OP_DIV ? '0 : sim[DW-1:0];
						status <= (z_s1 && op_s1 == OP_DIV) ? ST_DIV0 :
						          (sre[DW] || sim[DW]) ? ST_SAT : ST_OK;
					end
					if (div_go) begin
						state_q <= S_DIV;
						cnt_q   <= CW'(NW);
						den_q   <= dsq_s1;
						sre_q   <= re_c[PW-1];
						sim_q   <= im_c[PW-1];
						nre_q   <= NW'(re_c[PW-1] ? -re_c : re_c) << FRAC_BITS;
						nim_q   <= NW'(im_c[PW-1] ? -im_c : im_c) << FRAC_BITS;
						rre_q   <= '0;
						rim_q   <= '0;
					end
				end
				S_DIV: begin
					done <= 1'b0;
					if (!tre[PW]) begin
						rre_q <= tre;
						nre_q <= {nre_q[NW-2:0], 1'b1};
					end else begin
						rre_q <= {rre_q[PW-1:0], nre_q[NW-1]};
						nre_q <= {nre_q[NW-2:0], 1'b0};
					end
					if (!tim[PW]) begin
						rim_q <= tim;
						nim_q <= {nim_q[NW-2:0], 1'b1};
					end else begin
						rim_q <= {rim_q[PW-1:0], nim_q[NW-1]};
						nim_q <= {nim_q[NW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) state_q <= S_DONE;
				end
				S_DONE: begin
					done    <= 1'b1;
					res_re  <= sre[DW-1:0];
					res_im  <= sim[DW-1:0];
					status  <= (sre[DW] || sim[DW]) ? ST_SAT : ST_OK;
					state_q <= S_RUN;
				end
				default: begin
					done    <= 1'b0;
					state_q <= S_RUN;
				end
			endcase
		end
	end

endmodule

[hdl/complex_arith_unit.sv]
// ---------------------------------------------------------------------------
// Complex arithmetic unit
// Adds, subtracts, multiplies or divides two complex Q16.16 operands.
// ---------------------------------------------------------------------------
// A command transfers when start is high and busy is low. The front end holds
// up to four commands in a queue; busy rises only when that queue is full.
// With the queue empty, add, subtract and multiply results appear on res_re,
// res_im and status, done high for one cycle, after the queue, the stage-one
// and the output registers; these commands stream at one per cycle while no
// divide holds the back end. A divide by a zero magnitude streams the same way.
// Any other divide runs the restoring divider at one quotient bit per cycle
// (2*DATA_WIDTH+2+FRAC_BITS quotient bits, 82 by default); its result is
// registered in the S_DONE state and the back end takes no new command until
// that result is out. The receiver cannot stall; each result is shown exactly
// once. Reset empties the queue and clears done.
// ---------------------------------------------------------------------------
module complex_arith_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            cmd,
	input  logic [DATA_WIDTH-1:0] a_re,
	input  logic [DATA_WIDTH-1:0] a_im,
	input  logic [DATA_WIDTH-1:0] b_re,
	input  logic [DATA_WIDTH-1:0] b_im,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] res_re,
	output logic [DATA_WIDTH-1:0] res_im,
	output logic [1:0]            status
);

	logic pop, q_valid, q_zero;
	op_t  q_op;
	logic [DATA_WIDTH-1:0] q_a_re, q_a_im, q_b_re, q_b_im;

	cau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk, .arst_n, .start, .cmd, .a_re, .a_im, .b_re, .b_im, .pop, .busy,
		.q_valid, .q_op, .q_zero, .q_a_re, .q_a_im, .q_b_re, .q_b_im
	);

	cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_op, .q_zero, .q_a_re, .q_a_im, .q_b_re,
		.q_b_im, .pop, .done, .res_re, .res_im, .status
	);

endmodule

[hdl/cau_checker.sv]
// ---------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level properties of the command and result channels.
// ---------------------------------------------------------------------------
module cau_checker import cau_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status
);

	a_no_done_in_reset: assert property (@(posedge clk) !arst_n |-> !done)
		else $error("done high during reset");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != ST_RSVD)
		else $error("reserved status code");
	a_idle_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !busy)
		else $error("busy right after reset");
	a_known_handshake: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({start, busy, done}))
		else $error("unknown handshake signal");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
	.clk, .arst_n, .start, .busy, .done, .status
);

[test/tb_complex_arith_unit.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Sends add, subtract, multiply and divide commands with directed corner
// operands and random operands under random start gaps, predicts each result
// with exact wide arithmetic and compares it in order with the done results.
// ---------------------------------------------------------------------------
module tb_complex_arith_unit;
	import cau_pkg::*;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam longint CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		status_t       st;
	} cplx_result_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [1:0]    cmd;
	logic [DW-1:0] a_re, a_im, b_re, b_im;
	logic          done;
	logic [DW-1:0] res_re, res_im;
	logic [1:0]    status;

	cplx_result_t  pending_results[$];
	int            error_count;
	int            result_count;
	int            op_count[4];
	longint        cycle_count;
	bit            no_gaps;

	complex_arith_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.done(done), .res_re(res_re), .res_im(res_im), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [DW-1:0] clamp(input logic signed [199:0] v, inout bit ovf);
		logic signed [199:0] hi, lo;
		hi = (200'sd1 <<< (DW - 1)) - 1;
		lo = -(200'sd1 <<< (DW - 1));
		if (v > hi) begin
			ovf = 1'b1;
			return hi[DW-1:0];
		end
		if (v < lo) begin
			ovf = 1'b1;
			return lo[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	// Quotient truncated toward zero.
	function automatic logic signed [199:0] quot_trunc(input logic signed [199:0] n,
			input logic signed [199:0] d);
		logic signed [199:0] mag;
		mag = (n < 0 ? -n : n) / d;
		return n < 0 ? -mag : mag;
	endfunction

	function automatic cplx_result_t predict_cplx(input op_t op, input logic [DW-1:0] ar,
			input logic [DW-1:0] ai, input logic [DW-1:0] br, input logic [DW-1:0] bi);
		logic signed [199:0] xr, xi, yr, yi, re, im, den;
		cplx_result_t r;
		bit ovf;
		xr = $signed(ar);
		xi = $signed(ai);
		yr = $signed(br);
		yi = $signed(bi);
		ovf = 1'b0;
		case (op)
			OP_ADD: begin
				re = xr + yr;
				im = xi + yi;
			end
			OP_SUB: begin
				re = xr - yr;
				im = xi - yi;
			end
			OP_MUL: begin
				re = (xr * yr - xi * yi) >>> FB;
				im = (xr * yi + xi * yr) >>> FB;
			end
			default: begin
				den = yr * yr + yi * yi;
				if (den == 0) begin
					r.re = '0;
					r.im = '0;
					r.st = ST_DIV0;
					return r;
				end
				re = quot_trunc((xr * yr + xi * yi) <<< FB, den);
				im = quot_trunc((xi * yr - xr * yi) <<< FB, den);
			end
		endcase
		r.re = clamp(re, ovf);
		r.im = clamp(im, ovf);
		r.st = ovf ? ST_SAT : ST_OK;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DW-1:0] got,
			input logic [DW-1:0] want);
		error_count++;
		$display("Mismatch at result %0d: %s got %h expected %h", result_count, what, got,
			want);
	endtask

	task automatic send_command(input op_t op, input logic [DW-1:0] ar,
			input logic [DW-1:0] ai, input logic [DW-1:0] br, input logic [DW-1:0] bi);
		if (!no_gaps) begin
			while ($urandom_range(99) < 24) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start <= 1'b1;
		cmd <= op;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(predict_cplx(op, ar, ai, br, bi));
		op_count[op]++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cplx_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected res_re", res_re, '0);
			end else begin
				want = pending_results.pop_front();
				if (res_re !== want.re) report_mismatch("res_re", res_re, want.re);
				if (res_im !== want.im) report_mismatch("res_im", res_im, want.im);
				if (status !== want.st) report_mismatch("status", DW'(status), DW'(want.st));
			end
			result_count++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout with %0d results outstanding", pending_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [DW-1:0] pick_operand();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
			4: return DW'($signed($urandom_range(65535) - 32768) <<< 8);
			5: return DW'($signed($urandom_range(511) - 256));
			default: return $urandom;
		endcase
	endfunction

	task automatic test_add_sub_extremes();
		send_command(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		send_command(OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
		send_command(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		send_command(OP_SUB, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_command(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_multiply();
		send_command(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFB_0000);
		send_command(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_command(OP_MUL, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
		send_command(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
		send_command(OP_MUL, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
	endtask

	task automatic test_divide();
		send_command(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
		send_command(OP_DIV, 32'h0006_0000, 32'hFFFC_0000, 32'h0002_0000, 32'h0000_0000);
		send_command(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
		send_command(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0003_0000, 32'h0007_0000);
		send_command(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_command(OP_DIV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_command(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
	endtask

	task automatic test_random_stream(input int count);
		op_t op;
		for (int i = 0; i < count; i++) begin
			no_gaps = (i >= count / 2) && (i < count / 2 + 200);
			// Divides are slow, so they are kept to a modest share.
			op = ($urandom_range(99) < 15) ? OP_DIV : op_t'($urandom_range(2));
			send_command(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = OP_ADD;
		a_re = '0;
		a_im = '0;
		b_re = '0;
		b_im = '0;
		no_gaps = 1'b0;
		error_count = 0;
		result_count = 0;
		cycle_count = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_add_sub_extremes();
		test_multiply();
		test_divide();
		test_random_stream(2000);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d add, %0d sub, %0d mul, %0d div commands; %0d results checked.",
			op_count[0], op_count[1], op_count[2], op_count[3], result_count);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches found.", error_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/cau_pkg.sv
hdl/cau_front.sv
hdl/cau_back.sv
hdl/complex_arith_unit.sv
hdl/cau_checker.sv
test/tb_complex_arith_unit.sv
